@@ hw/rtl/sat_pkg.sv @@
// Shared types, constants and helpers for the summed-area table block.
// Depends on nothing; used by sat_ctrl, sat_dpath and summed_area_table_rect_sum.
`default_nettype none

package sat_pkg;

   // Grid capacity
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 64;

   // Fixed field widths
   localparam int CFG_W   = 7;
   localparam int COORD_W = 6;
   localparam int ELEM_W  = 32;
   localparam int SUM_W   = 64;

   // Derived widths
   localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
   localparam int COLS_W     = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(64);

   typedef enum logic {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_OVERRUN    = 2'd1,
      STATUS_INCOMPLETE = 2'd2,
      STATUS_BAD_RECT   = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept_load;
      logic accept_query;
      logic load_write;
      logic query_second;
      logic query_finish;
   } cmd_type;

   function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
      logic [ROWS_W-1:0] res;
      if (v == '0) begin
         res = ROWS_W'(1);
      end else if (32'(v) > MAX_ROWS) begin
         res = ROWS_W'(MAX_ROWS);
      end else begin
         res = ROWS_W'(v);
      end
      return res;
   endfunction

   function automatic logic [COLS_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
      logic [COLS_W-1:0] res;
      if (v == '0) begin
         res = COLS_W'(1);
      end else if (32'(v) > MAX_COLUMNS) begin
         res = COLS_W'(MAX_COLUMNS);
      end else begin
         res = COLS_W'(v);
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] table_addr(input logic [ROW_IDX_W-1:0] row,
                                                    input logic [COL_IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col));
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sat_ctrl.sv @@
// Sequencing state machine for the summed-area table block.
// Depends on sat_pkg; drives the command struct into sat_dpath.
`default_nettype none

module sat_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             opcode,
   output logic                  busy,
   output sat_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_LOAD_WR = 4'b0010,
      ST_QRY_RD2 = 4'b0100,
      ST_QRY_SUM = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.accept_load   = accept & (opcode == sat_pkg::OP_LOAD);
      cmd.accept_query  = accept & (opcode == sat_pkg::OP_QUERY);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_load) begin
               state_in = ST_LOAD_WR;
            end else if (cmd.accept_query) begin
               state_in = ST_QRY_RD2;
            end
         end
         ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_QRY_RD2: begin
            cmd.query_second = 1'b1;
            state_in         = ST_QRY_SUM;
         end
         ST_QRY_SUM: begin
            cmd.query_finish = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/sat_dpath.sv @@
// Datapath of the summed-area table block: size registers, load position,
// the two-read-port table memory and the corner combine. Depends on sat_pkg.
`default_nettype none

module sat_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sat_pkg::cmd_type                   cmd,
   input  wire logic                               csr_write_enable,
   input  wire logic                               csr_index,
   input  wire logic [sat_pkg::CFG_W-1:0]          csr_write_data,
   input  wire logic                               first_element,
   input  wire logic signed [sat_pkg::ELEM_W-1:0]  element_value,
   input  wire logic [sat_pkg::COORD_W-1:0]        top_row,
   input  wire logic [sat_pkg::COORD_W-1:0]        left_column,
   input  wire logic [sat_pkg::COORD_W-1:0]        bottom_row,
   input  wire logic [sat_pkg::COORD_W-1:0]        right_column,
   output logic                                    rsp_valid,
   output logic signed [sat_pkg::SUM_W-1:0]        rsp_rect_sum,
   output logic [1:0]                              rsp_status
);

   localparam int SW = sat_pkg::SUM_W;

   // Size registers and load position
   logic [sat_pkg::CFG_W-1:0]   rows_cfg_ff, rows_cfg_in;
   logic [sat_pkg::CFG_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [sat_pkg::ROWS_W-1:0]  load_row_ff, load_row_in;
   logic [sat_pkg::COLS_W-1:0]  load_col_ff, load_col_in;
   logic [SW-1:0]               row_sum_ff, row_sum_in;
   logic                        complete_ff, complete_in;

   // Per-transaction working registers
   logic [sat_pkg::ROW_IDX_W-1:0] wr_row_ff, wr_row_in;
   logic [sat_pkg::COL_IDX_W-1:0] wr_col_ff, wr_col_in;
   logic [SW-1:0]                 wr_sum_ff, wr_sum_in;
   logic                          top_zero_ff, top_zero_in;
   logic                          left_zero_ff, left_zero_in;
   logic [sat_pkg::ROW_IDX_W-1:0] q_bot_ff, q_bot_in;
   logic [sat_pkg::ROW_IDX_W-1:0] q_top_ff, q_top_in;
   logic [sat_pkg::COL_IDX_W-1:0] q_left_ff, q_left_in;
   logic [SW-1:0]                 partial_ff, partial_in;
   sat_pkg::status_type           status_ff, status_in;

   // Response registers
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]               rsp_sum_ff, rsp_sum_in;
   sat_pkg::status_type         rsp_status_ff, rsp_status_in;

   // Table memory
   logic [SW-1:0]               area_table [sat_pkg::DEPTH];
   logic [SW-1:0]               rd_a_ff, rd_b_ff;
   logic [sat_pkg::ADDR_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
   logic [SW-1:0]               wr_data;
   logic                        wr_en;

   // Load-side helpers
   logic [sat_pkg::ROWS_W-1:0]  rows_eff, eff_row, row_next;
   logic [sat_pkg::COLS_W-1:0]  cols_eff, eff_col, col_next;
   logic [SW-1:0]               eff_sum, elem_sum;
   logic                        eff_complete, overrun, wrap;
   logic                        bad_rect;

   assign rows_eff = sat_pkg::clamp_rows(rows_cfg_ff);
   assign cols_eff = sat_pkg::clamp_cols(cols_cfg_ff);

   // A load with first_element set restarts the grid before anything else
   assign eff_row      = first_element ? '0 : load_row_ff;
   assign eff_col      = first_element ? '0 : load_col_ff;
   assign eff_sum      = first_element ? '0 : row_sum_ff;
   assign eff_complete = first_element ? 1'b0 : complete_ff;
   assign overrun      = (eff_row >= rows_eff) || (eff_col >= cols_eff);
   assign elem_sum     = eff_sum + SW'(element_value);
   assign col_next     = eff_col + 1'b1;
   assign row_next     = eff_row + 1'b1;
   assign wrap         = (col_next >= cols_eff);

   assign bad_rect = (top_row > bottom_row) || (left_column > right_column) ||
                     (32'(bottom_row) >= 32'(rows_eff)) ||
                     (32'(right_column) >= 32'(cols_eff));

   always_comb begin
      rows_cfg_in   = rows_cfg_ff;
      cols_cfg_in   = cols_cfg_ff;
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      row_sum_in    = row_sum_ff;
      complete_in   = complete_ff;
      wr_row_in     = wr_row_ff;
      wr_col_in     = wr_col_ff;
      wr_sum_in     = wr_sum_ff;
      top_zero_in   = top_zero_ff;
      left_zero_in  = left_zero_ff;
      q_bot_in      = q_bot_ff;
      q_top_in      = q_top_ff;
      q_left_in     = q_left_ff;
      partial_in    = partial_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr_a     = sat_pkg::table_addr(sat_pkg::ROW_IDX_W'(eff_row - 1'b1),
                                          sat_pkg::COL_IDX_W'(eff_col));
      rd_addr_b     = sat_pkg::table_addr(q_top_ff, q_left_ff);
      wr_addr       = sat_pkg::table_addr(wr_row_ff, wr_col_ff);
      wr_data       = (top_zero_ff ? '0 : rd_a_ff) + wr_sum_ff;
      wr_en         = 1'b0;

      priority if (cmd.accept_load) begin
         // Read the entry above; advance the position now unless it overruns, write next cycle
         wr_row_in   = sat_pkg::ROW_IDX_W'(eff_row);
         wr_col_in   = sat_pkg::COL_IDX_W'(eff_col);
         wr_sum_in   = elem_sum;
         top_zero_in = (eff_row == '0);
         status_in   = overrun ? sat_pkg::STATUS_OVERRUN : sat_pkg::STATUS_OK;
         load_row_in = eff_row;
         load_col_in = eff_col;
         row_sum_in  = eff_sum;
         complete_in = eff_complete;
         if (!overrun) begin
            if (wrap) begin
               load_col_in = '0;
               row_sum_in  = '0;
               load_row_in = row_next;
               complete_in = eff_complete | (row_next >= rows_eff);
            end else begin
               load_col_in = col_next;
               row_sum_in  = elem_sum;
            end
         end
      end else if (cmd.accept_query) begin
         // First corner pair: S(b+1, r+1) on port A, S(t, r+1) on port B
         rd_addr_a    = sat_pkg::table_addr(sat_pkg::ROW_IDX_W'(bottom_row),
                                            sat_pkg::COL_IDX_W'(right_column));
         rd_addr_b    = sat_pkg::table_addr(sat_pkg::ROW_IDX_W'(top_row - 1'b1),
                                            sat_pkg::COL_IDX_W'(right_column));
         q_bot_in     = sat_pkg::ROW_IDX_W'(bottom_row);
         q_top_in     = sat_pkg::ROW_IDX_W'(top_row - 1'b1);
         q_left_in    = sat_pkg::COL_IDX_W'(left_column - 1'b1);
         top_zero_in  = (top_row == '0);
         left_zero_in = (left_column == '0);
         if (!complete_ff) begin
            status_in = sat_pkg::STATUS_INCOMPLETE;
         end else if (bad_rect) begin
            status_in = sat_pkg::STATUS_BAD_RECT;
         end else begin
            status_in = sat_pkg::STATUS_OK;
         end
      end else if (cmd.load_write) begin
         wr_en         = (status_ff == sat_pkg::STATUS_OK);
         rsp_valid_in  = 1'b1;
         rsp_sum_in    = '0;
         rsp_status_in = status_ff;
      end else if (cmd.query_second) begin
         // Second corner pair: S(b+1, l) on port A, S(t, l) on port B
         rd_addr_a  = sat_pkg::table_addr(q_bot_ff, q_left_ff);
         rd_addr_b  = sat_pkg::table_addr(q_top_ff, q_left_ff);
         partial_in = rd_a_ff - (top_zero_ff ? '0 : rd_b_ff);
      end else if (cmd.query_finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (status_ff == sat_pkg::STATUS_OK) begin
            rsp_sum_in = partial_ff - (left_zero_ff ? '0 : rd_a_ff)
                       + ((top_zero_ff | left_zero_ff) ? '0 : rd_b_ff);
         end else begin
            rsp_sum_in = '0;
         end
      end else if (csr_write_enable) begin
         // Any size change drops the current grid
         unique case (csr_index)
            sat_pkg::CSR_ROW_COUNT:    rows_cfg_in = csr_write_data;
            sat_pkg::CSR_COLUMN_COUNT: cols_cfg_in = csr_write_data;
            default:                   rows_cfg_in = rows_cfg_ff;
         endcase
         load_row_in = '0;
         load_col_in = '0;
         row_sum_in  = '0;
         complete_in = 1'b0;
      end else begin
         // Idle: hold everything
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= sat_pkg::CFG_SIZE_RESET;
         cols_cfg_ff  <= sat_pkg::CFG_SIZE_RESET;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         row_sum_ff   <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         row_sum_ff   <= row_sum_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_row_ff     <= wr_row_in;
      wr_col_ff     <= wr_col_in;
      wr_sum_ff     <= wr_sum_in;
      top_zero_ff   <= top_zero_in;
      left_zero_ff  <= left_zero_in;
      q_bot_ff      <= q_bot_in;
      q_top_ff      <= q_top_in;
      q_left_ff     <= q_left_in;
      partial_ff    <= partial_in;
      status_ff     <= status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         area_table[wr_addr] <= wr_data;
      end
      rd_a_ff <= area_table[rd_addr_a];
      rd_b_ff <= area_table[rd_addr_b];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rect_sum = rsp_sum_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire

@@ hw/rtl/summed_area_table_rect_sum.sv @@
// Top level of the summed-area table block: joins sat_ctrl and sat_dpath.
// Depends on sat_pkg, sat_ctrl and sat_dpath.
`default_nettype none

// Usage:
//   Request channel: drive start with the req_ fields; a transaction is taken
//   at a rising edge where start is high and busy is low. req_opcode selects a
//   load (next grid element, row-major, req_first_element restarts the grid)
//   or a rectangle-sum query over rows req_top_row..req_bottom_row and
//   columns req_left_column..req_right_column, inclusive.
//   Response channel: rsp_valid pulses for exactly one cycle per transaction,
//   with rsp_rect_sum and rsp_status. The receiver cannot stall; take the
//   response in that cycle. Loads and errors return a zero sum.
//   Timing: a load reads the entry above when taken and writes its own in
//   ST_LOAD_WR. A query reads the four table corners through the two read
//   ports of the table memory, when taken and in ST_QRY_RD2, and combines
//   them in ST_QRY_SUM. busy stays high until ST_LOAD_WR or ST_QRY_SUM has
//   registered the response; no new transaction is taken before that.
//   Configuration: csr_index 0 is the row count, 1 the column count; write
//   only while idle. A write drops the loaded grid, so reload it.
//   Reset: sizes return to 64 x 64, the grid is empty and no response is
//   pending. The table contents are not cleared; every entry is written by
//   a load before any query result can use it.
module summed_area_table_rect_sum (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_opcode,
   input  wire logic                               req_first_element,
   input  wire logic signed [sat_pkg::ELEM_W-1:0]  req_element_value,
   input  wire logic [sat_pkg::COORD_W-1:0]        req_top_row,
   input  wire logic [sat_pkg::COORD_W-1:0]        req_left_column,
   input  wire logic [sat_pkg::COORD_W-1:0]        req_bottom_row,
   input  wire logic [sat_pkg::COORD_W-1:0]        req_right_column,
   output logic                                    rsp_valid,
   output logic signed [sat_pkg::SUM_W-1:0]        rsp_rect_sum,
   output logic [1:0]                              rsp_status,
   input  wire logic                               csr_write_enable,
   input  wire logic                               csr_index,
   input  wire logic [sat_pkg::CFG_W-1:0]          csr_write_data
);

   sat_pkg::cmd_type cmd;

   // Sequence each transaction
   sat_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Hold sizes, load position and table; combine corners
   sat_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .first_element    (req_first_element),
      .element_value    (req_element_value),
      .top_row          (req_top_row),
      .left_column      (req_left_column),
      .bottom_row       (req_bottom_row),
      .right_column     (req_right_column),
      .rsp_valid        (rsp_valid),
      .rsp_rect_sum     (rsp_rect_sum),
      .rsp_status       (rsp_status)
   );

   // An accepted transaction keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   // A load answers once its ST_LOAD_WR state has registered the response
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == sat_pkg::OP_LOAD) |-> ##2 rsp_valid)
      else $error("load response missing");

   // A query answers once it has passed through ST_QRY_RD2 and ST_QRY_SUM
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == sat_pkg::OP_QUERY) |-> ##3 rsp_valid)
      else $error("query response missing");

   // Any error status carries a zero sum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sat_pkg::STATUS_OK) |-> (rsp_rect_sum == '0))
      else $error("nonzero sum with error status");

endmodule

`default_nettype wire
